// ===== rtl/life_generation_step_core_macros.svh =====
// assertion macros used by the port checker file
`ifndef LIFE_GENERATION_STEP_CORE_MACROS_SVH
`define LIFE_GENERATION_STEP_CORE_MACROS_SVH

// same-cycle implication, clocked on aclk, off while in reset
`define LGS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off while in reset
`define LGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lgs_pkg.sv =====
// shared types and constants of the life generation step core
package lgs_pkg;

    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int OUT_POS_W  = 10;
    localparam int WIN_ROWS   = 3;
    localparam int WIN_CELLS  = 2;
    localparam int LINE_W     = 2;
    localparam int NEIGHBOURS = 8;
    localparam int NBR_W      = $clog2(NEIGHBOURS + 1);

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int MIN_SIZE     = 2;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

    // request codes
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // rule b3/s23
    localparam logic [NBR_W-1:0] LIVE_BIRTH = NBR_W'(3);
    localparam logic [NBR_W-1:0] LIVE_KEEP  = NBR_W'(2);

    // bit positions in a line store entry
    localparam int LINE_ABOVE     = 0;
    localparam int LINE_TWO_ABOVE = 1;

    // window column, bit 0 top row, bit 2 bottom row
    localparam int ROW_TOP = 0;
    localparam int ROW_MID = 1;
    localparam int ROW_BOT = 2;

    typedef logic [WIN_ROWS-1:0] lgs_col_t;

    typedef struct packed {
        logic wrap_col;
        logic first_col;
        logic last_col;
        logic first_row;
        logic last_row;
    } lgs_mask_t;

endpackage

// ===== rtl/lgs_line_store.sv =====
// two-bit line store memory with write-first read register
module lgs_line_store
    import lgs_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_COLS
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [LINE_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [LINE_W-1:0]        rd_data
);

    logic [LINE_W-1:0] line_mem_reg [DEPTH];
    logic [LINE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            line_mem_reg[wr_addr] <= wr_data;
        end
    end

    // forward a same-address write to the read register
    always_ff @(posedge aclk) begin
        if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_reg <= wr_data;
        end else begin
            rd_data_reg <= line_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/lgs_col_cell.sv =====
// one window column cell, shifts its column to the next cell
module lgs_col_cell
    import lgs_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  lgs_col_t col_in,
    output lgs_col_t col_out
);

    lgs_col_t col_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else if (shift_en) begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// ===== rtl/lgs_rule.sv =====
// border masking, neighbour count and b3/s23 decision
module lgs_rule
    import lgs_pkg::*;
(
    input  lgs_col_t  left_col,
    input  lgs_col_t  centre_col,
    input  lgs_col_t  right_col,
    input  lgs_mask_t mask,
    output logic      next_alive
);

    lgs_col_t         l_m;
    lgs_col_t         c_m;
    lgs_col_t         r_m;
    logic [NBR_W-1:0] count;

    always_comb begin
        l_m = mask.first_col ? '0 : left_col;
        c_m = centre_col;
        r_m = (mask.wrap_col || mask.last_col) ? '0 : right_col;
        if (mask.first_row) begin
            l_m[ROW_TOP] = 1'b0;
            c_m[ROW_TOP] = 1'b0;
            r_m[ROW_TOP] = 1'b0;
        end
        if (mask.last_row) begin
            l_m[ROW_BOT] = 1'b0;
            c_m[ROW_BOT] = 1'b0;
            r_m[ROW_BOT] = 1'b0;
        end
        count = NBR_W'(l_m[ROW_TOP]) + NBR_W'(l_m[ROW_MID]) + NBR_W'(l_m[ROW_BOT])
              + NBR_W'(c_m[ROW_TOP]) + NBR_W'(c_m[ROW_BOT])
              + NBR_W'(r_m[ROW_TOP]) + NBR_W'(r_m[ROW_MID]) + NBR_W'(r_m[ROW_BOT]);
        next_alive = (count == LIVE_BIRTH) || (c_m[ROW_MID] && (count == LIVE_KEEP));
    end

endmodule

// ===== rtl/life_generation_step_core.sv =====
// life generation step core: one b3/s23 generation over a raster cell stream
//
// Takes one cell word per clock while s_ready is high and gives the next-generation
// state of the cell that lies cols+1 words earlier in the stream, so a grid of
// rows x cols cells needs rows*cols push words followed by cols+1 flush words to
// drain; the first cols+1 words of a frame give no result. Throughput is one word
// per clock, sustained while the result sink keeps up, set by the single line store
// port pair (one read, one write each cycle): the read for the next column is issued
// while the current column is written, so the store data is ready when the next
// word arrives. A result sits in the output register in the cycle after its word is
// taken, and the input keeps taking words while that register drains. Cells outside
// the grid count as dead. Grid sizes come from the grid_rows and grid_cols registers,
// used clamped to [2, MAX_ROWS] and [2, MAX_COLS]; write them only while the core is
// idle. The word that yields the result flagged frame_last ends the frame and the
// next word starts a new one. The line stores need no clearing after reset: entries
// that were never written only ever land on masked border neighbours.
module life_generation_step_core
    import lgs_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration write port
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // input word channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_req_type,
    input  logic                 s_cell_alive,
    // result word channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_next_alive,
    output logic [OUT_POS_W-1:0] m_out_row,
    output logic [OUT_POS_W-1:0] m_out_col,
    output logic                 m_frame_last
);

    // widths of column and row indexes, clamped sizes and the warm-up counter
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COLS_W  = $clog2(MAX_COLS + 1);
    localparam int ROWS_W  = $clog2(MAX_ROWS + 1);
    localparam int SEEN_W  = $clog2(MAX_COLS + 2);
    localparam int CC_W    = (COLS_W > CFG_W) ? COLS_W : CFG_W;
    localparam int RC_W    = (ROWS_W > CFG_W) ? ROWS_W : CFG_W;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_COLS + 1);

    // configuration registers
    logic [CFG_W-1:0] grid_rows_reg;
    logic [CFG_W-1:0] grid_cols_reg;

    // raster position of the next input and the next result, warm-up count
    logic [COL_W-1:0]  input_col_reg,  input_col_next;
    logic [COL_W-1:0]  result_col_reg, result_col_next;
    logic [ROW_W-1:0]  result_row_reg, result_row_next;
    logic [SEEN_W-1:0] cells_seen_reg, cells_seen_next;

    // output register
    logic                 m_valid_reg;
    logic                 m_next_alive_reg;
    logic [OUT_POS_W-1:0] m_out_row_reg;
    logic [OUT_POS_W-1:0] m_out_col_reg;
    logic                 m_frame_last_reg;

    logic [COLS_W-1:0] cols_eff;
    logic [ROWS_W-1:0] rows_eff;
    logic [COLS_W-1:0] cols_m1;
    logic [ROWS_W-1:0] rows_m1;

    logic              accept;
    logic              cell_in;
    logic [LINE_W-1:0] line_rd;
    logic [LINE_W-1:0] line_wr;
    lgs_col_t          win_chain [WIN_CELLS+1];
    lgs_mask_t         mask;
    logic              produce;
    logic              frame_last;
    logic              in_wrap;
    logic              next_alive;

    // config writes, decoded by index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_rows_reg <= SIZE_RESET;
            grid_cols_reg <= SIZE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_GRID_ROWS: grid_rows_reg <= cfg_wdata;
                REG_GRID_COLS: grid_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // sizes clamped to the supported range
    always_comb begin
        if (grid_cols_reg < CFG_W'(MIN_SIZE)) begin
            cols_eff = COLS_W'(MIN_SIZE);
        end else if (CC_W'(grid_cols_reg) > CC_W'(MAX_COLS)) begin
            cols_eff = COLS_W'(MAX_COLS);
        end else begin
            cols_eff = COLS_W'(grid_cols_reg);
        end
        if (grid_rows_reg < CFG_W'(MIN_SIZE)) begin
            rows_eff = ROWS_W'(MIN_SIZE);
        end else if (RC_W'(grid_rows_reg) > RC_W'(MAX_ROWS)) begin
            rows_eff = ROWS_W'(MAX_ROWS);
        end else begin
            rows_eff = ROWS_W'(grid_rows_reg);
        end
    end

    assign cols_m1 = cols_eff - COLS_W'(1);
    assign rows_m1 = rows_eff - ROWS_W'(1);

    // input side stalls only while a finished word waits and the sink holds it
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    // a flush shifts in a dead cell
    assign cell_in = (s_req_type == REQ_PUSH) ? s_cell_alive : 1'b0;

    // line stores: entry for this column holds the cells one and two rows up;
    // both shift down one row as the new cell goes in
    always_comb begin
        line_wr                 = '0;
        line_wr[LINE_ABOVE]     = cell_in;
        line_wr[LINE_TWO_ABOVE] = line_rd[LINE_ABOVE];
    end

    lgs_line_store #(
        .DEPTH (MAX_COLS)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (input_col_reg),
        .wr_data (line_wr),
        .rd_addr (input_col_next),
        .rd_data (line_rd)
    );

    // newest window column: two rows up, one row up, the incoming cell
    always_comb begin
        win_chain[0]          = '0;
        win_chain[0][ROW_TOP] = line_rd[LINE_TWO_ABOVE];
        win_chain[0][ROW_MID] = line_rd[LINE_ABOVE];
        win_chain[0][ROW_BOT] = cell_in;
    end

    // chain of column cells, each hands its column to the next on every word
    for (genvar i = 0; i < WIN_CELLS; i++) begin : g_win
        lgs_col_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (accept),
            .col_in   (win_chain[i]),
            .col_out  (win_chain[i+1])
        );
    end

    // border flags of the result cell; at column 0 of the input the newest
    // column belongs to the next row and is dropped
    always_comb begin
        mask.wrap_col  = (input_col_reg == '0);
        mask.first_col = (result_col_reg == '0);
        mask.last_col  = (COLS_W'(result_col_reg) >= cols_m1);
        mask.first_row = (result_row_reg == '0);
        mask.last_row  = (ROWS_W'(result_row_reg) >= rows_m1);
    end

    lgs_rule u_rule (
        .left_col   (win_chain[WIN_CELLS]),
        .centre_col (win_chain[1]),
        .right_col  (win_chain[0]),
        .mask       (mask),
        .next_alive (next_alive)
    );

    // results start once cols+1 words of the frame are in
    assign produce    = (cells_seen_reg > SEEN_W'(cols_eff));
    assign frame_last = mask.last_row && mask.last_col;
    assign in_wrap    = (COLS_W'(input_col_reg) >= cols_m1);

    // position counters; the frame's last result sends everything back to zero
    always_comb begin
        input_col_next  = input_col_reg;
        result_col_next = result_col_reg;
        result_row_next = result_row_reg;
        cells_seen_next = cells_seen_reg;
        if (accept) begin
            if (produce && frame_last) begin
                input_col_next  = '0;
                result_col_next = '0;
                result_row_next = '0;
                cells_seen_next = '0;
            end else begin
                if (produce) begin
                    if (mask.last_col) begin
                        result_col_next = '0;
                        result_row_next = result_row_reg + ROW_W'(1);
                    end else begin
                        result_col_next = result_col_reg + COL_W'(1);
                    end
                end
                input_col_next = in_wrap ? '0 : input_col_reg + COL_W'(1);
                if (cells_seen_reg != SEEN_MAX) begin
                    cells_seen_next = cells_seen_reg + SEEN_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            input_col_reg  <= '0;
            result_col_reg <= '0;
            result_row_reg <= '0;
            cells_seen_reg <= '0;
        end else begin
            input_col_reg  <= input_col_next;
            result_col_reg <= result_col_next;
            result_row_reg <= result_row_next;
            cells_seen_reg <= cells_seen_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept && produce) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (accept && produce) begin
            m_next_alive_reg <= next_alive;
            m_out_row_reg    <= OUT_POS_W'(result_row_reg);
            m_out_col_reg    <= OUT_POS_W'(result_col_reg);
            m_frame_last_reg <= frame_last;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_next_alive = m_next_alive_reg;
    assign m_out_row    = m_out_row_reg;
    assign m_out_col    = m_out_col_reg;
    assign m_frame_last = m_frame_last_reg;

endmodule

// ===== rtl/lgs_port_checker.sv =====
// port-level checks of the life generation step core, bound to the top level
`include "life_generation_step_core_macros.svh"

module lgs_port_checker
    import lgs_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 cfg_we,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [CFG_W-1:0]     cfg_wdata,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 s_req_type,
    input logic                 s_cell_alive,
    input logic                 m_valid,
    input logic                 m_ready,
    input logic                 m_next_alive,
    input logic [OUT_POS_W-1:0] m_out_row,
    input logic [OUT_POS_W-1:0] m_out_col,
    input logic                 m_frame_last
);

    // set at reset and after a frame's last word is taken: the next result
    // word opens a frame
    logic frame_open_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_open_reg <= 1'b1;
        end else if (m_valid && m_ready) begin
            frame_open_reg <= m_frame_last;
        end
    end

    `LGS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid, "result word dropped while stalled")
    `LGS_ASSERT_NEXT(a_out_stable, m_valid && !m_ready,
        $stable(m_next_alive) && $stable(m_out_row) && $stable(m_out_col)
        && $stable(m_frame_last), "result word changed while stalled")
    `LGS_ASSERT_NOW(a_in_ready, !m_valid || m_ready, s_ready, "input stalled with free output")
    `LGS_ASSERT_NOW(a_frame_start, m_valid && frame_open_reg,
        (m_out_row == '0) && (m_out_col == '0), "frame does not start at row 0 column 0")

endmodule

bind life_generation_step_core lgs_port_checker u_lgs_port_checker (.*);

// ===== test/tb_life_generation_step_core.sv =====
// self-checking testbench of the life generation step core with its own b3/s23 predictor
module tb_life_generation_step_core;
    timeunit 1ns;
    timeprecision 1ps;

    import lgs_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 9;
    // wait past the output register, enough for any word still in flight
    localparam int SETTLE_CYCLES   = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int WORDS_PER_PHASE = 320;

    // block ports, all inputs known from time zero
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = REG_GRID_ROWS;
    logic [CFG_W-1:0]     cfg_wdata    = '0;
    logic                 s_valid      = 1'b0;
    logic                 s_ready;
    logic                 s_req_type   = REQ_PUSH;
    logic                 s_cell_alive = 1'b0;
    logic                 m_valid;
    logic                 m_ready      = 1'b0;
    logic                 m_next_alive;
    logic [OUT_POS_W-1:0] m_out_row;
    logic [OUT_POS_W-1:0] m_out_col;
    logic                 m_frame_last;

    // one next-generation cell as the result channel carries it
    typedef struct packed {
        logic                 next_alive;
        logic [OUT_POS_W-1:0] row;
        logic [OUT_POS_W-1:0] col;
        logic                 frame_last;
    } life_cell_result_t;

    // next-generation cells still owed by the core, oldest first
    life_cell_result_t pending_cells[$];
    life_cell_result_t oldest_cell;

    // predictor copy of the core state
    bit [CFG_W-1:0] rows_setting = SIZE_RESET;
    bit [CFG_W-1:0] cols_setting = SIZE_RESET;
    bit             above_line     [DEF_MAX_COLS];
    bit             two_above_line [DEF_MAX_COLS];
    // window_cells[row][col], row 0 on top, col 0 the oldest column
    bit [2:0][2:0]  window_cells;
    int unsigned    in_row;
    int unsigned    in_col;
    int unsigned    res_row;
    int unsigned    res_col;
    int unsigned    cells_in_frame;

    // run bookkeeping
    int error_count       = 0;
    int words_sent        = 0;
    int cycle_count       = 0;
    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    life_generation_step_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_cell_alive (s_cell_alive),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_next_alive (m_next_alive),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_last (m_frame_last)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // grid size as the core uses it: clamped to [2, ceiling]
    function automatic int unsigned effective_size(input bit [CFG_W-1:0] setting,
                                                   input int unsigned ceiling);
        if (setting < MIN_SIZE) return MIN_SIZE;
        if (setting > ceiling) return ceiling;
        return setting;
    endfunction

    // advance the predictor by one accepted word, queue the cell it completes
    function automatic void predict_next_generation(input logic req, input logic alive);
        int unsigned       rows_n;
        int unsigned       cols_n;
        int unsigned       live_count;
        bit                cell_bit;
        bit                centre;
        bit                last;
        bit [2:0]          fresh;
        bit [2:0][2:0]     prior;
        bit [2:0][2:0]     nb;
        life_cell_result_t res;

        rows_n   = effective_size(rows_setting, DEF_MAX_ROWS);
        cols_n   = effective_size(cols_setting, DEF_MAX_COLS);
        // a flush inserts a dead cell whatever its alive bit says
        cell_bit = (req == REQ_PUSH) ? alive : 1'b0;
        prior    = window_cells;

        // new window column: two rows up, one row up, this word
        fresh          = '0;
        fresh[ROW_BOT] = cell_bit;
        if (in_col < DEF_MAX_COLS) begin
            fresh[ROW_TOP]         = two_above_line[in_col];
            fresh[ROW_MID]         = above_line[in_col];
            two_above_line[in_col] = fresh[ROW_MID];
            above_line[in_col]     = cell_bit;
        end
        for (int r = 0; r < 3; r++) begin
            window_cells[r] = {fresh[r], prior[r][2], prior[r][1]};
        end

        // the first cols+1 words of a frame only fill the window
        if (cells_in_frame >= cols_n + 1) begin
            for (int r = 0; r < 3; r++) begin
                // at the start of an input row the result sits on the right edge,
                // so the old window is used and its right neighbours are dead
                if (in_col == 0) begin
                    nb[r] = {1'b0, prior[r][2], prior[r][1]};
                end else begin
                    nb[r] = window_cells[r];
                end
                if (res_col == 0) nb[r][0] = 1'b0;
                if (res_col >= cols_n - 1) nb[r][2] = 1'b0;
            end
            // rows above the top and below the bottom are dead
            if (res_row == 0) nb[ROW_TOP] = '0;
            if (res_row >= rows_n - 1) nb[ROW_BOT] = '0;

            live_count = 0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    if (!(r == 1 && k == 1)) live_count += nb[r][k];
                end
            end
            centre = nb[ROW_MID][1];
            last   = (res_row >= rows_n - 1) && (res_col >= cols_n - 1);

            res.next_alive = (live_count == LIVE_BIRTH) || (centre && live_count == LIVE_KEEP);
            res.row        = res_row[OUT_POS_W-1:0];
            res.col        = res_col[OUT_POS_W-1:0];
            res.frame_last = last;
            pending_cells.push_back(res);

            // frame end: every counter back to zero, next word opens a new frame
            if (last) begin
                in_row         = 0;
                in_col         = 0;
                res_row        = 0;
                res_col        = 0;
                cells_in_frame = 0;
                return;
            end
            if (res_col + 1 >= cols_n) begin
                res_col = 0;
                if (res_row < 'hFFFF) res_row++;
            end else begin
                res_col++;
            end
        end

        if (in_col + 1 >= cols_n) begin
            in_col = 0;
            if (in_row < 'hFFFF) in_row++;
        end else begin
            in_col++;
        end
        if (cells_in_frame < 'h1FFFFF) cells_in_frame++;
    endfunction

    // one input word; valid holds with a steady payload until taken
    task automatic send_cell_word(input logic req, input logic alive);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_cell_alive <= alive;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predict_next_generation(req, alive);
        words_sent++;
    endtask

    // hold off the sender until the core has handed over every owed cell
    task automatic wait_results_drained();
        s_valid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // resize the grid; only ever called on a closed frame
    task automatic write_grid_size(input logic [CFG_W-1:0] rows_w,
                                   input logic [CFG_W-1:0] cols_w);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_index <= REG_GRID_ROWS;
        cfg_wdata <= rows_w;
        @(posedge aclk);
        rows_setting = rows_w;
        cfg_index <= REG_GRID_COLS;
        cfg_wdata <= cols_w;
        @(posedge aclk);
        cols_setting = cols_w;
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    // one whole frame of random cells, then the cols+1 words that drain it
    task automatic send_frame(input logic [CFG_W-1:0] rows_w, input logic [CFG_W-1:0] cols_w,
                              input bit resize, input int alive_pct, input int flush_pct,
                              input int pause_at);
        int unsigned rows_n;
        int unsigned cols_n;
        bit          is_flush;

        if (resize) write_grid_size(rows_w, cols_w);
        rows_n = effective_size(rows_setting, DEF_MAX_ROWS);
        cols_n = effective_size(cols_setting, DEF_MAX_COLS);
        for (int i = 0; i < rows_n * cols_n; i++) begin
            // sender stops mid-frame until the result side has caught up
            if (i == pause_at) wait_results_drained();
            // early flushes stand in for dead cells
            is_flush = $urandom_range(99) < flush_pct;
            send_cell_word(is_flush ? REQ_FLUSH : REQ_PUSH, $urandom_range(99) < alive_pct);
        end
        // mostly flushes, with stray pushes that land below the bottom row
        for (int i = 0; i <= cols_n; i++) begin
            send_cell_word(($urandom_range(3) == 0) ? REQ_PUSH : REQ_FLUSH,
                           1'($urandom_range(1)));
        end
    endtask

    task automatic test_directed_shapes();
        // sizes written below the minimum clamp to 2x2; a full 2x2 block is a still life
        write_grid_size(11'd1, 11'd0);
        repeat (4) send_cell_word(REQ_PUSH, 1'b1);
        repeat (3) send_cell_word(REQ_FLUSH, 1'b0);
        // 3x3 blinker: vertical bar turns horizontal
        // first cell is a flush carrying a set alive bit, tail is live pushes below the grid
        write_grid_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++) begin
            if (i == 0) begin
                send_cell_word(REQ_FLUSH, 1'b1);
            end else begin
                send_cell_word(REQ_PUSH, (i % 3) == 1);
            end
        end
        repeat (4) send_cell_word(REQ_PUSH, 1'b1);
    endtask

    task automatic test_random_frames(input int send_idle, input int recv_idle,
                                      input int word_budget);
        int               start_words;
        logic [CFG_W-1:0] rows_w;
        logic [CFG_W-1:0] cols_w;

        sender_idle_pct   = send_idle;
        receiver_idle_pct = recv_idle;
        start_words       = words_sent;
        while (words_sent - start_words < word_budget) begin
            // mostly small grids, sometimes below the minimum, sometimes wider
            case ($urandom_range(9))
                0:       rows_w = CFG_W'($urandom_range(1));
                1:       rows_w = CFG_W'($urandom_range(16, 9));
                default: rows_w = CFG_W'($urandom_range(8, 2));
            endcase
            case ($urandom_range(9))
                0:       cols_w = CFG_W'($urandom_range(1));
                1:       cols_w = CFG_W'($urandom_range(24, 9));
                default: cols_w = CFG_W'($urandom_range(8, 2));
            endcase
            // frames without a resize follow the previous one back to back
            send_frame(rows_w, cols_w, $urandom_range(1) == 1, $urandom_range(90, 10),
                       ($urandom_range(3) == 0) ? 10 : 0, $urandom_range(60));
        end
    endtask

    task automatic test_size_extremes();
        // tall narrow grid with a forced mid-frame pause
        send_frame(11'd100, 11'd2, 1'b1, 50, 5, 100);
        // wide grid, height clamped up from zero
        send_frame(11'd0, 11'd200, 1'b1, 50, 5, -1);
    endtask

    // receiver stalls at random
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // compare each taken result word with the oldest owed cell
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_cells.size() == 0) begin
                $error("unexpected result word at row %0d col %0d", m_out_row, m_out_col);
                error_count++;
            end else begin
                oldest_cell = pending_cells.pop_front();
                if (m_next_alive !== oldest_cell.next_alive) begin
                    $error("next_alive: expected %0d, got %0d",
                           oldest_cell.next_alive, m_next_alive);
                    error_count++;
                end
                if (m_out_row !== oldest_cell.row) begin
                    $error("out_row: expected %0d, got %0d", oldest_cell.row, m_out_row);
                    error_count++;
                end
                if (m_out_col !== oldest_cell.col) begin
                    $error("out_col: expected %0d, got %0d", oldest_cell.col, m_out_col);
                    error_count++;
                end
                if (m_frame_last !== oldest_cell.frame_last) begin
                    $error("frame_last: expected %0d, got %0d",
                           oldest_cell.frame_last, m_frame_last);
                    error_count++;
                end
            end
        end
    end

    // watchdog against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender idles lightly while the receiver stalls hard, then the reverse, then none
        sender_idle_pct   = 30;
        receiver_idle_pct = 69;
        test_directed_shapes();
        test_random_frames(30, 69, WORDS_PER_PHASE);
        test_random_frames(69, 30, WORDS_PER_PHASE);
        test_random_frames(0, 0, WORDS_PER_PHASE);
        test_size_extremes();

        wait_results_drained();
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
